>>> rtl/tmje_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmje_pkg
// Shared types and character constants for the job executor.
// ----------------------------------------------------------------------------
package tmje_pkg;
  localparam logic [31:0] DASHES = 32'h2D2D2D2D;
  localparam logic [31:0] SPACES = 32'h20202020;
  localparam logic [7:0]  CH_H   = 8'h48;
  localparam logic [7:0]  CH_G   = 8'h47;
  localparam logic [7:0]  CH_D   = 8'h44;
  localparam logic [7:0]  CH_P   = 8'h50;
  localparam logic [7:0]  CH_L   = 8'h4C;
  localparam logic [7:0]  CH_R   = 8'h52;
  localparam logic [7:0]  CH_S   = 8'h53;
  localparam logic [7:0]  CH_C   = 8'h43;
  localparam logic [7:0]  CH_B   = 8'h42;
  localparam logic [7:0]  CH_T   = 8'h54;
  localparam logic [7:0]  CH_0   = 8'h30;
  localparam logic [7:0]  CH_DASH  = 8'h2D;
  localparam logic [7:0]  CH_SPACE = 8'h20;

  localparam logic [1:0] MODE_JOB  = 2'd0;
  localparam logic [1:0] MODE_PROG = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;
  localparam logic [1:0] MODE_EXEC = 2'd3;

  localparam logic [1:0] RS_LOADING = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_WAITING = 2'd2;
  localparam logic [1:0] RS_STOPPED = 2'd3;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_WORD   = 2'd1;
  localparam logic [1:0] RK_HALT   = 2'd2;

  // Memory port request from sequencer to word store.
  typedef struct packed {
    logic        we;
    logic [6:0]  addr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic logic [31:0] undash(input logic [31:0] w);
    logic [31:0] r;
    r = w;
    for (int k = 0; k < 4; k++) begin
      if (w[8*k +: 8] == CH_DASH) r[8*k +: 8] = CH_SPACE;
    end
    return r;
  endfunction
endpackage

>>> rtl/tmje_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmje_store
// Word memory, one port, read data registered; contents defined by writes.
// ----------------------------------------------------------------------------
module tmje_store import tmje_pkg::*; #(
  parameter int MEM_WORDS = 100
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);
  logic [31:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule

>>> rtl/tmje_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmje_seq
// Sequencer: decodes each beat, sweeps memory, reads/modifies/writes words.
// ----------------------------------------------------------------------------
module tmje_seq import tmje_pkg::*; #(
  parameter int MEM_WORDS   = 100,
  parameter int BLOCK_WORDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_card_word,
  input  logic        in_end_of_card,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_out_word,
  output logic        out_last_result,
  output logic [1:0]  out_run_state,
  output logic [6:0]  out_instr_counter,
  output logic        out_compare_flag,
  output mem_req_t    mreq,
  input  logic [31:0] mrdata
);
  localparam logic [6:0] MEMW = 7'(MEM_WORDS);
  localparam logic [3:0] BLKW = 4'(BLOCK_WORDS);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_OPRD  = 8'b0001_0000,
    S_OPEX  = 8'b0010_0000,
    S_PAD   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } st_t;

  st_t         st_r, st_nxt;
  logic [6:0]  clr_r, clr_nxt;
  logic        job_r, job_nxt;     // sweep was started by a job beat
  logic [31:0] gr_r, gr_nxt;
  logic [6:0]  ni_r, ni_nxt;
  logic        tg_r, tg_nxt;
  logic [1:0]  ms_r, ms_nxt;
  logic [6:0]  lp_r, lp_nxt;
  logic [3:0]  fi_r, fi_nxt;
  logic [6:0]  fb_r, fb_nxt;
  logic [12:0] addr_r, addr_nxt;   // decoded operand, two's complement
  logic        aval_r, aval_nxt;
  logic [15:0] op_r, op_nxt;
  logic [3:0]  pi_r, pi_nxt;       // PD word index
  logic        pd_r, pd_nxt;       // a PD is printing
  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic        ol_r, ol_nxt;

  logic        out_free;
  logic [12:0] a_sum;
  logic [12:0] pd_addr;
  logic        pd_ok;

  assign out_free = !ov_r || !out_stall;
  assign in_stall = !(st_r == S_IDLE) || ov_r;

  always_comb begin
    // address from chars 3 and 4, range -528..+2277, kept signed in 13 bits
    a_sum   = 13'(({5'd0, mrdata[15:8]} - 13'(CH_0)) * 13'd10)
            + ({5'd0, mrdata[7:0]} - 13'(CH_0));
    pd_addr = addr_r + 13'(pi_r);
    pd_ok   = !pd_addr[12] && (pd_addr < 13'(MEM_WORDS));
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; gr_nxt = gr_r; ni_nxt = ni_r; tg_nxt = tg_r;
    ms_nxt = ms_r; lp_nxt = lp_r; fi_nxt = fi_r; fb_nxt = fb_r;
    addr_nxt = addr_r; aval_nxt = aval_r; op_nxt = op_r; pi_nxt = pi_r;
    pd_nxt = pd_r; job_nxt = job_r;
    ov_nxt = ov_r && out_stall; ok_nxt = ok_r; ow_nxt = ow_r; ol_nxt = ol_r;
    mreq = '{we: 1'b0, addr: 7'd0, wdata: 32'd0};
    unique case (st_r)
      S_CLEAR: begin
        mreq = '{we: 1'b1, addr: clr_r, wdata: DASHES};
        clr_nxt = clr_r + 7'd1;
        if (clr_r == MEMW - 7'd1) begin
          // a job beat reports its status; the sweep after reset does not
          st_nxt = job_r ? S_EMIT : S_IDLE;
          job_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          unique case (in_mode)
            MODE_JOB: begin
              gr_nxt = '0; ni_nxt = '0; tg_nxt = 1'b0; ms_nxt = RS_LOADING;
              lp_nxt = '0; fi_nxt = '0; fb_nxt = '0; clr_nxt = '0;
              job_nxt = 1'b1;
              st_nxt = S_CLEAR;
            end
            MODE_PROG: begin
              if (lp_r < MEMW) begin
                mreq = '{we: 1'b1, addr: lp_r, wdata: in_card_word};
                lp_nxt = lp_r + 7'd1;
              end
              st_nxt = S_EMIT;
            end
            MODE_DATA: begin
              st_nxt = S_EMIT;
              if (ms_r == RS_WAITING) begin
                if (in_end_of_data) begin
                  ms_nxt = RS_RUNNING;
                end else begin
                  if (fi_r < BLKW) begin
                    if ({1'b0, fb_r} + {4'd0, fi_r} < {1'b0, MEMW}) begin
                      mreq = '{we: 1'b1, addr: 7'(fb_r + {3'd0, fi_r}),
                               wdata: in_card_word};
                    end
                    fi_nxt = fi_r + 4'd1;
                  end
                  if (in_end_of_card || fi_r + 4'd1 >= BLKW) begin
                    st_nxt = S_PAD;
                  end
                end
              end
            end
            MODE_EXEC: begin
              st_nxt = S_EMIT;
              if (ms_r == RS_LOADING || ms_r == RS_RUNNING) begin
                ms_nxt = RS_RUNNING;
                if (ni_r >= MEMW) begin
                  ms_nxt = RS_STOPPED;
                end else begin
                  mreq.addr = ni_r;
                  st_nxt = S_DEC;
                end
              end
            end
            default: st_nxt = S_EMIT;
          endcase
        end
      end
      S_FETCH: st_nxt = S_DEC;
      S_DEC: begin
        // instruction word now on read data
        op_nxt   = mrdata[31:16];
        aval_nxt = !a_sum[12] && (a_sum < 13'(MEM_WORDS));
        addr_nxt = a_sum;
        if (mrdata[31:24] == CH_H) begin
          ms_nxt = RS_STOPPED;
          ok_nxt = RK_HALT; ow_nxt = '0; ol_nxt = 1'b1; ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          ni_nxt = ni_r + 7'd1;
          mreq.addr = a_sum[6:0];
          pi_nxt = '0;
          pd_nxt = 1'b0;
          st_nxt = S_OPRD;
        end
      end
      S_OPRD: begin
        st_nxt = S_OPEX;
        if (pd_r) begin
          if (out_free) begin
            ok_nxt = RK_WORD;
            ow_nxt = undash(pd_ok ? mrdata : SPACES);
            ol_nxt = (pi_r == BLKW - 4'd1);
            ov_nxt = 1'b1;
            if (pi_r == BLKW - 4'd1) begin
              st_nxt = S_IDLE;
            end else begin
              pi_nxt = pi_r + 4'd1;
              mreq.addr = 7'(pd_addr + 13'd1);
              st_nxt = S_OPRD;
            end
          end else begin
            mreq.addr = pd_addr[6:0];
            st_nxt = S_OPRD;
          end
        end else begin
          // hold the operand address so its word is on read data in S_OPEX
          mreq.addr = addr_r[6:0];
        end
      end
      S_OPEX: begin
        st_nxt = S_EMIT;
        unique case (op_r)
          {CH_G, CH_D}: begin
            fb_nxt = aval_r ? addr_r[6:0] : MEMW;
            fi_nxt = '0;
            ms_nxt = RS_WAITING;
          end
          {CH_P, CH_D}: begin
            pd_nxt = 1'b1;
            mreq.addr = addr_r[6:0];
            st_nxt = S_OPRD;
          end
          {CH_L, CH_R}: gr_nxt = aval_r ? mrdata : SPACES;
          {CH_S, CH_R}: begin
            if (aval_r) mreq = '{we: 1'b1, addr: addr_r[6:0], wdata: gr_r};
          end
          {CH_C, CH_R}: tg_nxt = (gr_r == (aval_r ? mrdata : SPACES));
          {CH_B, CH_T}: begin
            if (tg_r) ni_nxt = aval_r ? addr_r[6:0] : MEMW;
          end
          default: ;
        endcase
      end
      S_PAD: begin
        if (fi_r < BLKW) begin
          if ({1'b0, fb_r} + {4'd0, fi_r} < {1'b0, MEMW}) begin
            mreq = '{we: 1'b1, addr: 7'(fb_r + {3'd0, fi_r}), wdata: SPACES};
          end
          fi_nxt = fi_r + 4'd1;
        end else begin
          ms_nxt = RS_RUNNING;
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ok_nxt = RK_STATUS; ow_nxt = '0; ol_nxt = 1'b1; ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; gr_r <= '0; ni_r <= '0; tg_r <= 1'b0;
      ms_r <= RS_LOADING; lp_r <= '0; fi_r <= '0; fb_r <= '0; pd_r <= 1'b0;
      pi_r <= '0; ov_r <= 1'b0; job_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; gr_r <= gr_nxt; ni_r <= ni_nxt;
      tg_r <= tg_nxt; ms_r <= ms_nxt; lp_r <= lp_nxt; fi_r <= fi_nxt;
      fb_r <= fb_nxt; pd_r <= pd_nxt; pi_r <= pi_nxt; ov_r <= ov_nxt;
      job_r <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; aval_r <= aval_nxt; op_r <= op_nxt;
    ok_r <= ok_nxt; ow_r <= ow_nxt; ol_r <= ol_nxt;
  end

  // Status fields reflect state after the item; they are settled once a beat
  // is shown, since no state changes while a result waits.
  assign out_valid         = ov_r;
  assign out_result_kind   = ok_r;
  assign out_out_word      = ow_r;
  assign out_last_result   = ol_r;
  assign out_run_state     = ms_r;
  assign out_instr_counter = ni_r;
  assign out_compare_flag  = tg_r;
endmodule

>>> rtl/teaching_machine_job_executor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teaching_machine_job_executor_top
// Four-character-word machine: loads jobs, runs one instruction per beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | mode, card_word, end_of_card/data
//  out_    | output    | out_valid/out_stall| kind, word, last, state, ic, flag
//
// Every job, program, data or instruction beat gives one result, a PD
// instruction one per word (10 words), one word per cycle while the output
// is not stalled. A completed card pads each remaining word with spaces.
// Job start and reset each sweep memory with dashes, taking no input beat;
// the reset sweep emits nothing. A stalled output holds the sequencer; the
// next input beat is taken the cycle after the last result is gone.
module teaching_machine_job_executor_top import tmje_pkg::*; #(
  parameter int MEM_WORDS   = 100,
  parameter int BLOCK_WORDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_card_word,
  input  logic        in_end_of_card,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_out_word,
  output logic        out_last_result,
  output logic [1:0]  out_run_state,
  output logic [6:0]  out_instr_counter,
  output logic        out_compare_flag
);
  mem_req_t    mreq;
  logic [31:0] mrdata;

  // Sequencer: owns all scalar machine state and the one memory port.
  tmje_seq #(.MEM_WORDS(MEM_WORDS), .BLOCK_WORDS(BLOCK_WORDS)) u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_card_word,
    .in_end_of_card, .in_end_of_data, .out_valid, .out_stall,
    .out_result_kind, .out_out_word, .out_last_result, .out_run_state,
    .out_instr_counter, .out_compare_flag, .mreq, .mrdata
  );

  // Word store: read data is registered and lands in the cycle after the address.
  tmje_store #(.MEM_WORDS(MEM_WORDS)) u_store (
    .clk, .req(mreq), .rdata(mrdata)
  );
endmodule

>>> rtl/tmje_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmje_checker
// Port-level checks on the job executor.
// ----------------------------------------------------------------------------
module tmje_checker import tmje_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic       out_last_result
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with result pending");
  a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_HALT |-> out_last_result)
    else $error("halt not last");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind != 2'd3) else $error("bad kind");
endmodule

bind teaching_machine_job_executor_top tmje_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_result_kind, .out_last_result
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the teaching-machine job executor: drives whole jobs
// (program load, instruction runs, data cards) through the input channel and
// checks every result beat against an in-bench model of the machine.
// ----------------------------------------------------------------------------
module testbench;
  import tmje_pkg::*;

  localparam int MEM = 100;
  localparam int BLK = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic        last;
    logic [1:0]  state;
    logic [6:0]  ic;
    logic        flag;
  } vm_result_t;

  // Machine model and the queue of result beats it predicts.
  class vm_scoreboard;
    logic [31:0] mem [MEM];
    logic [31:0] acc;
    int          ic;
    logic        flag;
    logic [1:0]  state;
    int          load_ptr;
    int          fill_idx;
    int          fill_base;
    vm_result_t  pending[$];
    int          errors;

    function void clear_job();
      for (int i = 0; i < MEM; i++) mem[i] = DASHES;
      acc = '0; ic = 0; flag = 1'b0; state = RS_LOADING;
      load_ptr = 0; fill_idx = 0; fill_base = 0;
    endfunction

    function logic [31:0] rd(int a);
      if (a < 0 || a >= MEM) return SPACES;
      return mem[a];
    endfunction

    function void wr(int a, logic [31:0] v);
      if (a >= 0 && a < MEM) mem[a] = v;
    endfunction

    function logic [31:0] blank_dashes(logic [31:0] w);
      logic [31:0] r;
      r = w;
      for (int k = 0; k < 4; k++)
        if (w[8*k +: 8] == CH_DASH) r[8*k +: 8] = CH_SPACE;
      return r;
    endfunction

    function void pad_card();
      while (fill_idx < BLK) begin
        wr(fill_base + fill_idx, SPACES);
        fill_idx++;
      end
      state = RS_RUNNING;
    endfunction

    // Note an accepted input beat and queue the results it causes.
    function void note_input(logic [1:0] mode, logic [31:0] w, logic eoc, logic eod);
      logic [1:0]  kinds[$];
      logic [31:0] words[$];
      logic [31:0] ir;
      int          addr;
      bit          ok;
      vm_result_t  r;
      case (mode)
        MODE_JOB: clear_job();
        MODE_PROG: begin
          if (load_ptr < MEM) begin
            mem[load_ptr] = w;
            load_ptr++;
          end
        end
        MODE_DATA: begin
          if (state == RS_WAITING) begin
            if (eod) state = RS_RUNNING;
            else begin
              if (fill_idx < BLK) begin
                wr(fill_base + fill_idx, w);
                fill_idx++;
              end
              if (eoc || fill_idx >= BLK) pad_card();
            end
          end
        end
        default: begin
          if (state == RS_LOADING) state = RS_RUNNING;
          if (state == RS_RUNNING) begin
            if (ic >= MEM) state = RS_STOPPED;
            else begin
              ir = mem[ic];
              if (ir[31:24] == CH_H) begin
                state = RS_STOPPED;
                kinds.push_back(RK_HALT);
                words.push_back('0);
              end else begin
                addr = (int'(ir[15:8]) - int'(CH_0)) * 10 + (int'(ir[7:0]) - int'(CH_0));
                ok = addr >= 0 && addr < MEM;
                ic++;
                if (ir[31:16] == {CH_G, CH_D}) begin
                  fill_base = ok ? addr : MEM;
                  fill_idx = 0;
                  state = RS_WAITING;
                end else if (ir[31:16] == {CH_P, CH_D}) begin
                  for (int i = 0; i < BLK; i++) begin
                    kinds.push_back(RK_WORD);
                    words.push_back(blank_dashes(rd(addr + i)));
                  end
                end else if (ir[31:16] == {CH_L, CH_R}) acc = rd(addr);
                else if (ir[31:16] == {CH_S, CH_R}) wr(addr, acc);
                else if (ir[31:16] == {CH_C, CH_R}) flag = (acc == rd(addr));
                else if (ir[31:16] == {CH_B, CH_T}) begin
                  if (flag) ic = ok ? addr : MEM;
                end
              end
            end
          end
        end
      endcase
      if (kinds.size() == 0) begin
        kinds.push_back(RK_STATUS);
        words.push_back('0);
      end
      foreach (kinds[k]) begin
        r.kind = kinds[k]; r.word = words[k];
        r.last = (k == kinds.size() - 1);
        r.state = state; r.ic = 7'(ic); r.flag = flag;
        pending.push_back(r);
      end
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(vm_result_t got);
      vm_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat kind=%0d word=%h", got.kind, got.word);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
      end
      if (got.word !== want.word) begin
        $error("out_word: expected %h, got %h", want.word, got.word); errors++;
      end
      if (got.last !== want.last) begin
        $error("last_result: expected %0d, got %0d", want.last, got.last); errors++;
      end
      if (got.state !== want.state) begin
        $error("run_state: expected %0d, got %0d", want.state, got.state); errors++;
      end
      if (got.ic !== want.ic) begin
        $error("instr_counter: expected %0d, got %0d", want.ic, got.ic); errors++;
      end
      if (got.flag !== want.flag) begin
        $error("compare_flag: expected %0d, got %0d", want.flag, got.flag); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_JOB;
  logic [31:0] in_card_word = '0;
  logic        in_end_of_card = 1'b0;
  logic        in_end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [31:0] out_out_word;
  logic        out_last_result;
  logic [1:0]  out_run_state;
  logic [6:0]  out_instr_counter;
  logic        out_compare_flag;

  vm_scoreboard vm = new();
  bit           quiet;      // no idling on either side while set
  int           sent;

  teaching_machine_job_executor_top u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample outputs at the rising edge; only accepted beats are checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      vm.check_result('{out_result_kind, out_out_word, out_last_result,
                        out_run_state, out_instr_counter, out_compare_flag});
  end

  // Receiver: stall about one cycle in ten, never while quiet.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 10);
  end

  // Send one beat; take a random idle gap first, hold until accepted.
  task automatic send_beat(logic [1:0] mode, logic [31:0] w,
                           logic eoc = 1'b0, logic eod = 1'b0);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_card_word <= w;
    in_end_of_card <= eoc;
    in_end_of_data <= eod;
    do @(posedge clk); while (in_stall);
    vm.note_input(mode, w, eoc, eod);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every expected beat, bounded by the watchdog.
  task automatic drain();
    while (vm.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] instr(logic [7:0] a, logic [7:0] b, int addr);
    return {a, b, 8'(CH_0 + addr / 10), 8'(CH_0 + addr % 10)};
  endfunction

  function automatic logic [31:0] any_word();
    return $urandom();
  endfunction

  // Random address: always in range, mostly low, sometimes near the top.
  function automatic int pick_addr();
    case ($urandom_range(0, 9))
      0: return 95 + $urandom_range(0, 4);
      1: return 90 + $urandom_range(0, 9);
      default: return $urandom_range(0, 49);
    endcase
  endfunction

  function automatic logic [31:0] rand_instr();
    int a;
    a = pick_addr();
    case ($urandom_range(0, 9))
      0, 1: return instr(CH_G, CH_D, a);
      2, 3: return instr(CH_P, CH_D, a);
      4: return instr(CH_L, CH_R, a);
      5: return instr(CH_S, CH_R, a);
      6: return instr(CH_C, CH_R, a);
      7: return instr(CH_B, CH_T, a);
      8: return {CH_H, 24'(any_word())};
      default: return any_word();
    endcase
  endfunction

  // One random job: load a program, then run it feeding cards on demand.
  task automatic random_job();
    int n;
    send_beat(MODE_JOB, any_word());
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) send_beat(MODE_PROG, rand_instr());
    if ($urandom_range(0, 1)) send_beat(MODE_PROG, {CH_H, 24'h202020});
    for (int s = 0; s < 16; s++) begin
      if (vm.state == RS_WAITING) begin
        n = $urandom_range(1, 11);
        for (int i = 0; i < n && vm.state == RS_WAITING; i++)
          send_beat(MODE_DATA, any_word(), i == n - 1 && $urandom_range(0, 3) != 0,
                    $urandom_range(0, 11) == 0);
      end else if ($urandom_range(0, 19) == 0) begin
        send_beat(MODE_DATA, any_word(), 1'($urandom()), 1'($urandom()));  // stray card
      end else begin
        send_beat(MODE_EXEC, any_word());
      end
      if (vm.state == RS_STOPPED) break;
    end
    if ($urandom_range(0, 3) == 0) send_beat(MODE_EXEC, any_word());
  endtask

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed job: every opcode but the halt, padding, END card, bad addresses.
    send_beat(MODE_JOB, '0);
    send_beat(MODE_PROG, instr(CH_G, CH_D, 20));
    send_beat(MODE_PROG, instr(CH_P, CH_D, 20));
    send_beat(MODE_PROG, instr(CH_L, CH_R, 20));
    send_beat(MODE_PROG, instr(CH_S, CH_R, 99));
    send_beat(MODE_PROG, instr(CH_C, CH_R, 99));
    send_beat(MODE_PROG, instr(CH_B, CH_T, 8));
    send_beat(MODE_PROG, 32'hFFFF_FFFF);            // unknown opcode
    send_beat(MODE_PROG, instr(CH_G, CH_D, 95));
    send_beat(MODE_PROG, instr(CH_P, CH_D, 95));    // reads past the end
    send_beat(MODE_PROG, {CH_G, CH_D, 16'h3A3A});   // invalid base
    send_beat(MODE_PROG, instr(CH_B, CH_T, 0) | 32'h0000_FFFF); // bad branch
    send_beat(MODE_DATA, 32'h0, 1'b1, 1'b0);        // ignored while loading
    send_beat(MODE_EXEC, '0);                       // GD 20
    send_beat(MODE_DATA, 32'h2D41_2D42);
    send_beat(MODE_DATA, 32'h0000_0000, 1'b1);      // short card
    send_beat(MODE_EXEC, '0);                       // PD 20
    for (int i = 0; i < 5; i++) send_beat(MODE_EXEC, '0);
    send_beat(MODE_DATA, '0, 1'b0, 1'b1);           // END card
    for (int i = 0; i < 3; i++) send_beat(MODE_EXEC, '0);
    for (int i = 0; i < 10; i++) send_beat(MODE_DATA, ~32'h0); // full card
    for (int i = 0; i < 4; i++) send_beat(MODE_EXEC, '0);
    drain();

    // Fill memory beyond the top, then run one instruction.
    send_beat(MODE_JOB, '0);
    quiet = 1'b1;
    for (int i = 0; i < 102; i++) send_beat(MODE_PROG, instr(CH_L, CH_R, i % 100));
    quiet = 1'b0;
    send_beat(MODE_EXEC, '0);
    drain();                                         // sender waits for all results

    while (sent < 260) begin
      quiet = (sent > 170 && sent < 220);
      random_job();
    end
    quiet = 1'b0;
    drain();
    repeat (40) @(negedge clk);
    if (vm.errors == 0 && vm.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/tmje_pkg.sv
rtl/tmje_store.sv
rtl/tmje_seq.sv
rtl/teaching_machine_job_executor_top.sv
rtl/tmje_checker.sv
sim/testbench.sv
